>>> rtl/core/qjtg_pkg.sv
// Shared types and constants of the quintic joint trajectory generator.
package qjtg_pkg;

   localparam int STEP_W  = 16;
   localparam int FRAC_W  = 16;
   localparam int TAU_W   = 17;
   localparam int MUL_B_W = 18;
   localparam int BLEND_W = 21;
   localparam int H_W     = 22;
   localparam int BIAS_W  = 37;
   localparam int DIV_CNT_W = 5;

   localparam logic [STEP_W-1:0] NUM_STEPS_RESET = 16'd100;
   localparam logic [TAU_W-1:0]  TAU_ONE         = 17'h10000;
   localparam logic [H_W-1:0]    H_OFFSET        = 22'd983040;
   localparam logic [BIAS_W-1:0] G_BIAS          = 37'h0A_0000_8000;
   localparam logic [BIAS_W-1:0] ROUND_HALF      = 37'h00_0000_8000;
   localparam logic [1:0]        LAST_ROUND      = 2'd2;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_START  = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_CANCEL = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_RUNNING  = 2'd0,
      STATUS_FINISHED = 2'd1,
      STATUS_CANCELED = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DIV,
      ST_HG,
      ST_G,
      ST_SM,
      ST_SR,
      ST_JM,
      ST_JR
   } state_type;

   typedef struct packed {
      logic              busy;
      logic [STEP_W-1:0] quotient;
   } div_status_type;

endpackage

>>> rtl/core/qjtg_div.sv
// Serial restoring divider forming the Q0.16 fraction i / num_steps.
module qjtg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qjtg_pkg::STEP_W-1:0]     dividend,
   input  logic [qjtg_pkg::STEP_W-1:0]     divisor,
   output qjtg_pkg::div_status_type        status
);

   logic                               busy_ff, busy_in;
   logic [qjtg_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [qjtg_pkg::STEP_W-1:0]        rem_ff, rem_in;
   logic [qjtg_pkg::STEP_W-1:0]        quo_ff, quo_in;
   logic [qjtg_pkg::STEP_W:0]          shifted;
   logic [qjtg_pkg::STEP_W:0]          trial;

   // The dividend is below the divisor, so only the 16 fraction bits remain.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = qjtg_pkg::DIV_CNT_W'(qjtg_pkg::FRAC_W);
         rem_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = trial[qjtg_pkg::STEP_W-1:0];
            quo_in = {quo_ff[qjtg_pkg::STEP_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[qjtg_pkg::STEP_W-1:0];
            quo_in = {quo_ff[qjtg_pkg::STEP_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == qjtg_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy     = busy_ff;
   assign status.quotient = quo_ff;

endmodule

>>> rtl/core/qjtg_mul.sv
// Shared signed multiplier with a registered product.
module qjtg_mul #(
   parameter int A_WIDTH = 22,
   parameter int B_WIDTH = 18
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [A_WIDTH-1:0]           a,
   input  logic signed [B_WIDTH-1:0]           b,
   output logic signed [A_WIDTH+B_WIDTH-1:0]   p
);

   logic signed [A_WIDTH+B_WIDTH-1:0] p_ff, p_in;

   always_comb begin
      p_in = (A_WIDTH+B_WIDTH)'(a) * (A_WIDTH+B_WIDTH)'(b);
   end

   // The product holds while en is low, so a stalled consumer can wait on it.
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

>>> rtl/core/quintic_joint_trajectory_generator_core.sv
// Top level: sequencer, joint stores and result register of the trajectory generator.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid/req_ready, type, joint, pos   | in
//  result  | rsp_valid/rsp_ready, joint, pos, status | out
//  csr     | csr_valid/csr_ready, num_steps          | in
//
// A tick that is not the final step runs the serial divider, then the blend on the
// shared multiplier (states HG, G, SM and SR) and then JM and JR for each joint.
// A final-step tick skips the divider. A load request leaves the sequencer idle;
// a start or a cancel that emits a status result passes through the emit state.
// Synchronous reset clears the joint stores, the step counter and disarms.
// A stalled result channel holds the sequencer at the next result.
module quintic_joint_trajectory_generator_core #(
   parameter int NUM_JOINTS = 6,
   parameter int POS_WIDTH  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_type,
   input  logic [((NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1)-1:0] req_joint_index,
   input  logic signed [POS_WIDTH-1:0]             req_start_position,
   input  logic signed [POS_WIDTH-1:0]             req_target_position,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [((NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1)-1:0] rsp_out_joint,
   output logic signed [POS_WIDTH-1:0]             rsp_commanded_position,
   output logic                                    rsp_last_of_run,
   output logic [1:0]                              rsp_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [qjtg_pkg::STEP_W-1:0]             csr_num_steps
);

   localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int AW = (POS_WIDTH + 1 > qjtg_pkg::H_W) ? POS_WIDTH + 1 : qjtg_pkg::H_W;
   localparam int BW = qjtg_pkg::MUL_B_W;
   localparam int PW = AW + BW;
   localparam int DW = PW - qjtg_pkg::FRAC_W;
   localparam int SW = DW + 1;
   localparam logic [JW-1:0] LAST_JOINT = JW'(NUM_JOINTS - 1);

   qjtg_pkg::state_type          state_ff, state_in;
   qjtg_pkg::req_code_type       req_code;
   qjtg_pkg::status_code_type    emit_status_ff, emit_status_in;
   qjtg_pkg::div_status_type     div_status;

   logic [qjtg_pkg::STEP_W-1:0]  num_steps_ff;
   logic [qjtg_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                         armed_ff, armed_in;
   logic                         final_ff, final_in;
   logic [JW-1:0]                joint_ff, joint_in;
   logic [1:0]                   rnd_ff, rnd_in;
   logic [qjtg_pkg::TAU_W-1:0]   tau_ff, tau_in;
   logic [qjtg_pkg::BLEND_W-1:0] r_ff, r_in;

   logic signed [POS_WIDTH-1:0]  start_store_ff  [NUM_JOINTS];
   logic signed [POS_WIDTH-1:0]  target_store_ff [NUM_JOINTS];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [JW-1:0]                rsp_joint_ff, rsp_joint_in;
   logic signed [POS_WIDTH-1:0]  rsp_position_ff, rsp_position_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;

   logic                         req_fire;
   logic                         load_ok;
   logic [qjtg_pkg::STEP_W:0]    next_i;
   logic                         tick_final;
   logic                         out_free;
   logic                         out_load;
   logic                         div_start;
   logic                         mul_en;
   logic signed [AW-1:0]         mul_a;
   logic signed [BW-1:0]         mul_b;
   logic signed [PW-1:0]         mul_p;
   logic signed [qjtg_pkg::H_W-1:0] h_term;
   logic [qjtg_pkg::H_W-1:0]     tau_wide;
   logic signed [PW-1:0]         g_sum;
   logic signed [PW-1:0]         rnd_sum;
   logic signed [POS_WIDTH-1:0]  start_sel;
   logic signed [POS_WIDTH-1:0]  target_sel;
   logic signed [AW-1:0]         diff;
   logic signed [DW-1:0]         delta;
   logic signed [SW-1:0]         pos_wide;
   logic [SW-POS_WIDTH:0]        pos_upper;
   logic signed [POS_WIDTH-1:0]  pos_sat;

   assign req_code  = qjtg_pkg::req_code_type'(req_type);
   assign req_ready = (state_ff == qjtg_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_ok   = 32'(req_joint_index) < NUM_JOINTS;

   assign next_i     = {1'b0, step_ff} + 1'b1;
   assign tick_final = (num_steps_ff == '0) || (next_i >= {1'b0, num_steps_ff});

   qjtg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (next_i[qjtg_pkg::STEP_W-1:0]),
      .divisor  (num_steps_ff),
      .status   (div_status)
   );

   qjtg_mul #(
      .A_WIDTH (AW),
      .B_WIDTH (BW)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   // Arithmetic around the shared multiplier.
   always_comb begin
      tau_wide   = qjtg_pkg::H_W'(tau_ff);
      h_term     = $signed((tau_wide << 2) + (tau_wide << 1) - qjtg_pkg::H_OFFSET);
      g_sum      = mul_p + PW'($signed({1'b0, qjtg_pkg::G_BIAS}));
      rnd_sum    = mul_p + PW'($signed({1'b0, qjtg_pkg::ROUND_HALF}));
      start_sel  = start_store_ff[joint_ff];
      target_sel = target_store_ff[joint_ff];
      diff       = AW'(target_sel) - AW'(start_sel);
      delta      = rnd_sum[PW-1:qjtg_pkg::FRAC_W];
      pos_wide   = SW'(start_sel) + SW'(delta);
      pos_upper  = pos_wide[SW-1:POS_WIDTH-1];
      if ((&pos_upper) || !(|pos_upper)) begin
         pos_sat = pos_wide[POS_WIDTH-1:0];
      end else if (pos_wide[SW-1]) begin
         pos_sat = {1'b1, {(POS_WIDTH-1){1'b0}}};
      end else begin
         pos_sat = {1'b0, {(POS_WIDTH-1){1'b1}}};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qjtg_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_code)
                  qjtg_pkg::REQ_START: begin
                     if (num_steps_ff == '0) begin
                        state_in = qjtg_pkg::ST_EMIT;
                     end
                  end
                  qjtg_pkg::REQ_TICK: begin
                     if (armed_ff) begin
                        state_in = tick_final ? qjtg_pkg::ST_HG : qjtg_pkg::ST_DIV;
                     end
                  end
                  qjtg_pkg::REQ_CANCEL: begin
                     if (armed_ff) begin
                        state_in = qjtg_pkg::ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         qjtg_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = qjtg_pkg::ST_IDLE;
            end
         end
         qjtg_pkg::ST_DIV: begin
            if (!div_status.busy) begin
               state_in = qjtg_pkg::ST_HG;
            end
         end
         qjtg_pkg::ST_HG: state_in = qjtg_pkg::ST_G;
         qjtg_pkg::ST_G:  state_in = qjtg_pkg::ST_SM;
         qjtg_pkg::ST_SM: state_in = qjtg_pkg::ST_SR;
         qjtg_pkg::ST_SR: begin
            state_in = (rnd_ff == qjtg_pkg::LAST_ROUND) ? qjtg_pkg::ST_JM : qjtg_pkg::ST_SM;
         end
         qjtg_pkg::ST_JM: state_in = qjtg_pkg::ST_JR;
         qjtg_pkg::ST_JR: begin
            if (out_free) begin
               state_in = (joint_ff == LAST_JOINT) ? qjtg_pkg::ST_IDLE : qjtg_pkg::ST_JM;
            end
         end
         default: state_in = qjtg_pkg::ST_IDLE;
      endcase
   end

   // Unit controls and result loading.
   always_comb begin
      div_start       = 1'b0;
      mul_en          = 1'b0;
      mul_a           = '0;
      mul_b           = '0;
      out_load        = 1'b0;
      rsp_joint_in    = rsp_joint_ff;
      rsp_position_in = rsp_position_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_status_in   = rsp_status_ff;
      case (state_ff)
         qjtg_pkg::ST_IDLE: begin
            div_start = req_fire && (req_code == qjtg_pkg::REQ_TICK) && armed_ff
                        && !tick_final;
         end
         qjtg_pkg::ST_EMIT: begin
            out_load        = out_free;
            rsp_joint_in    = '0;
            rsp_position_in = '0;
            rsp_last_in     = 1'b1;
            rsp_status_in   = emit_status_ff;
         end
         qjtg_pkg::ST_HG: begin
            // Inner factor numerator: tau * (6 tau - 15) in Q32.
            mul_en = 1'b1;
            mul_a  = AW'(h_term);
            mul_b  = BW'($signed({1'b0, tau_ff}));
         end
         qjtg_pkg::ST_SM: begin
            mul_en = 1'b1;
            mul_a  = AW'($signed({1'b0, r_ff}));
            mul_b  = BW'($signed({1'b0, tau_ff}));
         end
         qjtg_pkg::ST_JM: begin
            mul_en = 1'b1;
            mul_a  = diff;
            mul_b  = BW'($signed({1'b0, r_ff}));
         end
         qjtg_pkg::ST_JR: begin
            out_load        = out_free;
            rsp_joint_in    = joint_ff;
            rsp_position_in = pos_sat;
            rsp_last_in     = (joint_ff == LAST_JOINT);
            rsp_status_in   = final_ff ? qjtg_pkg::STATUS_FINISHED : qjtg_pkg::STATUS_RUNNING;
         end
         default: ;
      endcase
   end

   // Datapath and bookkeeping next values.
   always_comb begin
      step_in        = step_ff;
      armed_in       = armed_ff;
      final_in       = final_ff;
      emit_status_in = emit_status_ff;
      joint_in       = joint_ff;
      rnd_in         = rnd_ff;
      tau_in         = tau_ff;
      r_in           = r_ff;
      if (req_fire) begin
         case (req_code)
            qjtg_pkg::REQ_START: begin
               step_in        = '0;
               armed_in       = (num_steps_ff != '0);
               emit_status_in = qjtg_pkg::STATUS_FINISHED;
            end
            qjtg_pkg::REQ_TICK: begin
               if (armed_ff) begin
                  final_in = tick_final;
                  tau_in   = qjtg_pkg::TAU_ONE;
                  if (tick_final) begin
                     armed_in = 1'b0;
                     step_in  = num_steps_ff;
                  end else begin
                     step_in = next_i[qjtg_pkg::STEP_W-1:0];
                  end
               end
            end
            qjtg_pkg::REQ_CANCEL: begin
               if (armed_ff) begin
                  armed_in       = 1'b0;
                  emit_status_in = qjtg_pkg::STATUS_CANCELED;
               end
            end
            default: ;
         endcase
      end
      if (state_ff == qjtg_pkg::ST_DIV && !div_status.busy) begin
         tau_in = {1'b0, div_status.quotient};
      end
      if (state_ff == qjtg_pkg::ST_G) begin
         r_in   = g_sum[qjtg_pkg::BLEND_W+qjtg_pkg::FRAC_W-1:qjtg_pkg::FRAC_W];
         rnd_in = '0;
      end
      if (state_ff == qjtg_pkg::ST_SR) begin
         r_in   = rnd_sum[qjtg_pkg::BLEND_W+qjtg_pkg::FRAC_W-1:qjtg_pkg::FRAC_W];
         rnd_in = rnd_ff + 1'b1;
         joint_in = '0;
      end
      if (state_ff == qjtg_pkg::ST_JR && out_free) begin
         joint_in = joint_ff + 1'b1;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= qjtg_pkg::ST_IDLE;
         num_steps_ff   <= qjtg_pkg::NUM_STEPS_RESET;
         step_ff        <= '0;
         armed_ff       <= 1'b0;
         final_ff       <= 1'b0;
         emit_status_ff <= qjtg_pkg::STATUS_RUNNING;
         joint_ff       <= '0;
         rnd_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            start_store_ff[j]  <= '0;
            target_store_ff[j] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         armed_ff       <= armed_in;
         final_ff       <= final_in;
         emit_status_ff <= emit_status_in;
         joint_ff       <= joint_in;
         rnd_ff         <= rnd_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            num_steps_ff <= csr_num_steps;
         end
         if (req_fire && (req_code == qjtg_pkg::REQ_LOAD) && load_ok) begin
            start_store_ff[req_joint_index]  <= req_start_position;
            target_store_ff[req_joint_index] <= req_target_position;
         end
      end
   end

   always_ff @(posedge clock) begin
      tau_ff <= tau_in;
      r_ff   <= r_in;
      if (out_load) begin
         rsp_joint_ff    <= rsp_joint_in;
         rsp_position_ff <= rsp_position_in;
         rsp_last_ff     <= rsp_last_in;
         rsp_status_ff   <= rsp_status_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_out_joint          = rsp_joint_ff;
   assign rsp_commanded_position = rsp_position_ff;
   assign rsp_last_of_run        = rsp_last_ff;
   assign rsp_status             = rsp_status_ff;

   // The divider only runs while the sequencer waits on it.
   assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == qjtg_pkg::ST_DIV)
      else $error("divider busy outside the divide state");

   // A final step has already disarmed the block when its positions go out.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == qjtg_pkg::ST_JR && final_ff) |-> !armed_ff)
      else $error("final step still armed");

   // The fraction never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == qjtg_pkg::ST_HG) |-> tau_ff <= qjtg_pkg::TAU_ONE)
      else $error("tau above one");

   // The finished blend lies in [0, 1].
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == qjtg_pkg::ST_JM) |-> r_ff <= qjtg_pkg::BLEND_W'(qjtg_pkg::TAU_ONE))
      else $error("blend above one");

endmodule

>>> tb/qjtg_checker.sv
`timescale 1ns / 1ps
// Result predictor and scoreboard for the quintic joint trajectory generator.
module qjtg_checker #(
   parameter int NUM_JOINTS = 6,
   parameter int POS_WIDTH  = 16,
   parameter int JOINT_W    = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [JOINT_W-1:0]          req_joint_index,
   input  logic signed [POS_WIDTH-1:0] req_start_position,
   input  logic signed [POS_WIDTH-1:0] req_target_position,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [JOINT_W-1:0]          rsp_out_joint,
   input  logic signed [POS_WIDTH-1:0] rsp_commanded_position,
   input  logic                        rsp_last_of_run,
   input  logic [1:0]                  rsp_status,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [qjtg_pkg::STEP_W-1:0] csr_num_steps,
   output int                          fail_count,
   output int                          outstanding,
   output int                          checked_count
);

   typedef struct {
      logic [JOINT_W-1:0]        joint;
      logic signed [POS_WIDTH-1:0] position;
      logic                      last;
      qjtg_pkg::status_code_type status;
   } position_result_type;

   localparam longint POS_HI = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
   localparam longint POS_LO = -POS_HI - 1;

   position_result_type         expected_positions[$];
   logic signed [POS_WIDTH-1:0] joint_start[NUM_JOINTS];
   logic signed [POS_WIDTH-1:0] joint_target[NUM_JOINTS];
   logic [qjtg_pkg::STEP_W-1:0] step_count;
   logic [qjtg_pkg::STEP_W-1:0] steps_setting;
   logic                        armed;
   int                          errors = 0;
   int                          checked = 0;

   assign fail_count    = errors;
   assign checked_count = checked;

   // Quintic blend 10t^3 - 15t^4 + 6t^5 evaluated as t^3 * (6t^2 - 15t + 10) in Q16.
   function automatic longint unsigned quintic_blend(input longint unsigned tau);
      longint unsigned inner;
      longint unsigned acc;
      inner = 64'd6 * tau * tau + (64'd10 << 32) - ((64'd15 * tau) << 16);
      acc   = (inner + 64'd32768) >> 16;
      repeat (3) acc = (acc * tau + 64'd32768) >> 16;
      return acc;
   endfunction

   function automatic logic signed [POS_WIDTH-1:0] blended_position(
      input logic signed [POS_WIDTH-1:0] from_pos,
      input logic signed [POS_WIDTH-1:0] to_pos,
      input longint unsigned             blend
   );
      longint span;
      longint delta;
      longint pos;
      span  = longint'(to_pos) - longint'(from_pos);
      delta = (span * longint'(blend) + 32768) >>> 16;
      pos   = longint'(from_pos) + delta;
      if (pos > POS_HI) pos = POS_HI;
      if (pos < POS_LO) pos = POS_LO;
      return pos[POS_WIDTH-1:0];
   endfunction

   task automatic push_position(input int joint, input longint pos, input logic last,
                                input qjtg_pkg::status_code_type status);
      position_result_type r;
      r.joint    = joint[JOINT_W-1:0];
      r.position = pos[POS_WIDTH-1:0];
      r.last     = last;
      r.status   = status;
      expected_positions.push_back(r);
   endtask

   task automatic predict_tick();
      logic [qjtg_pkg::TAU_W-1:0] next_step;
      logic                       final_step;
      longint unsigned            tau;
      longint unsigned            blend;
      next_step  = {1'b0, step_count} + 1'b1;
      final_step = (steps_setting == '0) || (next_step >= {1'b0, steps_setting});
      tau        = final_step ? 64'd65536 : (64'(next_step) << 16) / 64'(steps_setting);
      blend      = quintic_blend(tau);
      for (int j = 0; j < NUM_JOINTS; j++) begin
         push_position(j, blended_position(joint_start[j], joint_target[j], blend),
                       (j == NUM_JOINTS - 1),
                       final_step ? qjtg_pkg::STATUS_FINISHED : qjtg_pkg::STATUS_RUNNING);
      end
      if (final_step) begin
         armed      = 1'b0;
         step_count = steps_setting;
      end else begin
         step_count = next_step[qjtg_pkg::STEP_W-1:0];
      end
   endtask

   task automatic predict_request();
      case (qjtg_pkg::req_code_type'(req_type))
         qjtg_pkg::REQ_LOAD: begin
            if (req_joint_index < NUM_JOINTS) begin
               joint_start[req_joint_index]  = req_start_position;
               joint_target[req_joint_index] = req_target_position;
            end
         end
         qjtg_pkg::REQ_START: begin
            step_count = '0;
            if (steps_setting == '0) begin
               armed = 1'b0;
               push_position(0, 0, 1'b1, qjtg_pkg::STATUS_FINISHED);
            end else begin
               armed = 1'b1;
            end
         end
         qjtg_pkg::REQ_TICK: begin
            if (armed) predict_tick();
         end
         qjtg_pkg::REQ_CANCEL: begin
            if (armed) begin
               armed = 1'b0;
               push_position(0, 0, 1'b1, qjtg_pkg::STATUS_CANCELED);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      position_result_type e;
      if (expected_positions.size() == 0) begin
         $error("result with no request pending: joint %0d, position %0d",
                rsp_out_joint, rsp_commanded_position);
         errors++;
         return;
      end
      e = expected_positions.pop_front();
      checked++;
      if (rsp_out_joint !== e.joint) begin
         $error("out_joint: expected %0d, actual %0d", e.joint, rsp_out_joint);
         errors++;
      end
      if (rsp_commanded_position !== e.position) begin
         $error("commanded_position: expected %0d, actual %0d",
                e.position, rsp_commanded_position);
         errors++;
      end
      if (rsp_last_of_run !== e.last) begin
         $error("last_of_run: expected %0d, actual %0d", e.last, rsp_last_of_run);
         errors++;
      end
      if (rsp_status !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, rsp_status);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_positions.delete();
         for (int j = 0; j < NUM_JOINTS; j++) begin
            joint_start[j]  = '0;
            joint_target[j] = '0;
         end
         step_count    = '0;
         steps_setting = qjtg_pkg::NUM_STEPS_RESET;
         armed         = 1'b0;
      end else begin
         // A result leaving at this edge can only belong to an earlier request.
         if (rsp_valid && rsp_ready) check_result();
         if (csr_valid && csr_ready) steps_setting = csr_num_steps;
         if (req_valid && req_ready) predict_request();
      end
      outstanding <= expected_positions.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the quintic joint trajectory generator testbench.
module tb_top;

   localparam int NUM_JOINTS   = 6;
   localparam int POS_WIDTH    = 16;
   localparam int JOINT_W      = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int RANDOM_ITEMS = 300;
   localparam int SETTLE       = 50;
   localparam int LONG_STALL   = 400;
   localparam int CYCLE_LIMIT  = 400000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_type;
   logic [JOINT_W-1:0]          req_joint_index;
   logic signed [POS_WIDTH-1:0] req_start_position;
   logic signed [POS_WIDTH-1:0] req_target_position;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [JOINT_W-1:0]          rsp_out_joint;
   logic signed [POS_WIDTH-1:0] rsp_commanded_position;
   logic                        rsp_last_of_run;
   logic [1:0]                  rsp_status;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [qjtg_pkg::STEP_W-1:0] csr_num_steps;

   int fail_count;
   int outstanding;
   int checked_count;

   int send_idle  = 18;
   int recv_idle  = 49;
   int stalls_asked  = 0;
   int stalls_served = 0;
   int stall_left    = 0;
   int cycle_count   = 0;
   int sent_count    = 0;
   int csr_writes    = 0;
   int runs          = 0;
   logic [qjtg_pkg::STEP_W-1:0] steps_now = qjtg_pkg::NUM_STEPS_RESET;

   quintic_joint_trajectory_generator_core #(
      .NUM_JOINTS (NUM_JOINTS),
      .POS_WIDTH  (POS_WIDTH)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_joint_index        (req_joint_index),
      .req_start_position     (req_start_position),
      .req_target_position    (req_target_position),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_joint          (rsp_out_joint),
      .rsp_commanded_position (rsp_commanded_position),
      .rsp_last_of_run        (rsp_last_of_run),
      .rsp_status             (rsp_status),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_num_steps          (csr_num_steps)
   );

   qjtg_checker #(
      .NUM_JOINTS (NUM_JOINTS),
      .POS_WIDTH  (POS_WIDTH),
      .JOINT_W    (JOINT_W)
   ) u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_joint_index        (req_joint_index),
      .req_start_position     (req_start_position),
      .req_target_position    (req_target_position),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_joint          (rsp_out_joint),
      .rsp_commanded_position (rsp_commanded_position),
      .rsp_last_of_run        (rsp_last_of_run),
      .rsp_status             (rsp_status),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_num_steps          (csr_num_steps),
      .fail_count             (fail_count),
      .outstanding            (outstanding),
      .checked_count          (checked_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: random back-pressure, plus long hold-offs on demand.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_served != stalls_asked) begin
         rsp_ready     <= 1'b0;
         stall_left    <= LONG_STALL;
         stalls_served <= stalls_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   function automatic logic [POS_WIDTH-1:0] rand_pos();
      case ($urandom_range(0, 7))
         0:       return {1'b1, {(POS_WIDTH-1){1'b0}}};
         1:       return {1'b0, {(POS_WIDTH-1){1'b1}}};
         default: return POS_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [qjtg_pkg::STEP_W-1:0] pick_steps();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return qjtg_pkg::STEP_W'($urandom_range(1, 12));
      if (r < 93) return qjtg_pkg::STEP_W'($urandom_range(13, 40));
      if (r < 96) return '0;
      if (r < 98) return qjtg_pkg::STEP_W'($urandom_range(0, 65535));
      return '1;
   endfunction

   task automatic set_idle(input int sender_pct, input int receiver_pct);
      send_idle = sender_pct;
      recv_idle <= receiver_pct;
   endtask

   // Every call starts just after a rising edge and returns at the edge that
   // accepted the request, with valid still high.
   task automatic send_req(input qjtg_pkg::req_code_type kind,
                           input logic [JOINT_W-1:0] joint,
                           input logic [POS_WIDTH-1:0] from_pos,
                           input logic [POS_WIDTH-1:0] to_pos);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_joint_index     <= joint;
      req_start_position  <= from_pos;
      req_target_position <= to_pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_kind(input qjtg_pkg::req_code_type kind);
      send_req(kind, JOINT_W'($urandom_range(0, 7)), rand_pos(), rand_pos());
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [qjtg_pkg::STEP_W-1:0] value);
      wait_for_results();
      csr_valid     <= 1'b1;
      csr_num_steps <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      steps_now = value;
      csr_writes++;
   endtask

   initial begin
      int base_sent;
      int noise_count;
      int progress;
      int choice;
      int pick;
      int n_ticks;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_type            <= qjtg_pkg::REQ_LOAD;
      req_joint_index     <= '0;
      req_start_position  <= '0;
      req_target_position <= '0;
      csr_valid           <= 1'b0;
      csr_num_steps       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from the reset step count of 100.
      set_idle(18, 49);
      send_kind(qjtg_pkg::REQ_TICK);
      send_kind(qjtg_pkg::REQ_CANCEL);
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(0), 16'h8000, 16'h7FFF);
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(1), 16'h7FFF, 16'h8000);
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(2), 16'h0000, 16'h0000);
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(3), 16'hFFFF, 16'h0001);
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(4), rand_pos(), rand_pos());
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(5), 16'd100, -16'sd100);
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(6), 16'h1234, 16'h5678);
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(7), 16'hFFFF, 16'hFFFF);
      send_kind(qjtg_pkg::REQ_START);
      send_kind(qjtg_pkg::REQ_TICK);
      send_kind(qjtg_pkg::REQ_TICK);
      // A load while a run is in progress takes effect on the next step.
      send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(2), 16'h8000, 16'h7FFF);
      send_kind(qjtg_pkg::REQ_TICK);
      send_kind(qjtg_pkg::REQ_START);
      send_kind(qjtg_pkg::REQ_TICK);
      send_kind(qjtg_pkg::REQ_CANCEL);
      write_csr('0);
      send_kind(qjtg_pkg::REQ_START);
      send_kind(qjtg_pkg::REQ_TICK);
      write_csr('1);
      send_kind(qjtg_pkg::REQ_START);
      send_kind(qjtg_pkg::REQ_TICK);
      send_kind(qjtg_pkg::REQ_CANCEL);
      write_csr(16'd10);
      send_kind(qjtg_pkg::REQ_START);
      repeat (3) send_kind(qjtg_pkg::REQ_TICK);
      // Lowering the step count below the current step forces the final step.
      write_csr(16'd2);
      send_kind(qjtg_pkg::REQ_TICK);
      send_kind(qjtg_pkg::REQ_TICK);
      write_csr(16'd1);
      send_kind(qjtg_pkg::REQ_START);
      send_kind(qjtg_pkg::REQ_TICK);

      // Hold off the result side long enough that the block backs up its input.
      write_csr(16'd24);
      for (int j = 0; j < NUM_JOINTS; j++)
         send_req(qjtg_pkg::REQ_LOAD, JOINT_W'(j), rand_pos(), rand_pos());
      send_kind(qjtg_pkg::REQ_START);
      stalls_asked <= stalls_asked + 1;
      repeat (12) send_kind(qjtg_pkg::REQ_TICK);

      base_sent   = sent_count;
      noise_count = 0;
      progress    = 0;
      while (progress < RANDOM_ITEMS) begin
         if (progress < RANDOM_ITEMS / 3) set_idle(18, 49);
         else if (progress < 2 * RANDOM_ITEMS / 3) set_idle(49, 18);
         else set_idle(0, 0);
         choice = $urandom_range(0, 9);
         if (choice <= 6) begin
            if ($urandom_range(0, 2) == 0) write_csr(pick_steps());
            repeat ($urandom_range(1, NUM_JOINTS))
               send_req(qjtg_pkg::REQ_LOAD, JOINT_W'($urandom_range(0, 7)), rand_pos(),
                        rand_pos());
            send_kind(qjtg_pkg::REQ_START);
            n_ticks = (steps_now > 16) ? 16 : steps_now;
            for (int k = 0; k < n_ticks; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 90) begin
                  send_kind(qjtg_pkg::REQ_TICK);
               end else if (pick < 94) begin
                  send_req(qjtg_pkg::REQ_LOAD, JOINT_W'($urandom_range(0, 7)), rand_pos(),
                           rand_pos());
               end else if (pick < 97) begin
                  send_kind(qjtg_pkg::REQ_START);
               end else begin
                  send_kind(qjtg_pkg::REQ_CANCEL);
                  break;
               end
            end
            if (steps_now > 16 || $urandom_range(0, 3) == 0)
               send_kind($urandom_range(0, 1) ? qjtg_pkg::REQ_CANCEL : qjtg_pkg::REQ_TICK);
            runs++;
         end else if (choice <= 8) begin
            repeat (4) begin
               send_kind(qjtg_pkg::req_code_type'($urandom_range(0, 3)));
               noise_count++;
            end
         end else begin
            write_csr(qjtg_pkg::STEP_W'($urandom_range(8, 16)));
            send_kind(qjtg_pkg::REQ_START);
            repeat (4) send_kind(qjtg_pkg::REQ_TICK);
            write_csr(qjtg_pkg::STEP_W'($urandom_range(1, 3)));
            send_kind(qjtg_pkg::REQ_TICK);
            runs++;
         end
         progress = sent_count - base_sent - noise_count;
      end

      wait_for_results();
      $display("Sent %0d requests over %0d random runs with %0d step count writes.",
               sent_count, runs, csr_writes);
      $display("Compared %0d results against the prediction, %0d mismatches.",
               checked_count, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
